// ===== src/exptok_pkg.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer package
// Shared sizes, result types, name and operator tables and small helpers.
// ----------------------------------------------------------------------------
package exptok_pkg;

   // Longest expression that is counted exactly; later characters saturate.
   localparam int MAX_EXPR_LEN = 1024;
   localparam int CNT_W        = $clog2(MAX_EXPR_LEN + 1);

   // Saturation limits of the result fields.
   localparam int POS_SAT = 1023;
   localparam int LEN_SAT = 1024;

   // Result queue between the lexer and the output channel.
   localparam int RSP_DEPTH = 4;
   localparam int PTR_W     = $clog2(RSP_DEPTH);
   localparam int LVL_W     = $clog2(RSP_DEPTH + 1);

   localparam int NAME_COUNT = 16;
   localparam int FUNC_COUNT = 14;
   localparam int OP_COUNT   = 8;

   // Byte 0 of each name sits in bits 7:0.
   localparam logic [31:0] NAME_ROM [NAME_COUNT] = '{
      32'h006E6973, 32'h00736F63, 32'h006E6174, 32'h006E7463,
      32'h74727173, 32'h00776F70, 32'h00736261, 32'h00707865,
      32'h00676F6C, 32'h00006E6C, 32'h686E6973, 32'h68736F63,
      32'h686E6174, 32'h686E7463, 32'h69705F63, 32'h00655F63
   };
   localparam logic [2:0] NAME_LEN [NAME_COUNT] = '{
      3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3,
      3'd3, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3
   };
   localparam logic [7:0] OP_ROM [OP_COUNT] = '{
      8'h28, 8'h29, 8'h2C, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h5E
   };

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_1     = 8'h31;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UZ    = 8'h5A;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LZ    = 8'h7A;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   typedef enum logic [2:0] {
      KIND_OPERATOR = 3'd0,
      KIND_NUMBER   = 3'd1,
      KIND_FUNCTION = 3'd2,
      KIND_CONSTANT = 3'd3,
      KIND_VARIABLE = 3'd4,
      KIND_INVALID  = 3'd5,
      KIND_END      = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  code;
      logic [9:0]  position;
      logic [10:0] length;
      logic        ok;
      logic        run_last;
   } result_type;

   // Up to two result words caused by one input word, packed from first.
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } lex_out_type;

   function automatic logic [9:0] sat_pos(input logic [CNT_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w > 32'(POS_SAT)) sat_pos = 10'(POS_SAT);
      else sat_pos = w[9:0];
   endfunction

   function automatic logic [10:0] sat_len(input logic [CNT_W-1:0] v);
      logic [31:0] w;
      w = 32'(v);
      if (w > 32'(LEN_SAT)) sat_len = 11'(LEN_SAT);
      else sat_len = w[10:0];
   endfunction

   // Characters that may appear in a variable name.
   function automatic logic is_var_char(input logic [7:0] c);
      is_var_char = (c == CHAR_UNDER) ||
                    (c >= CHAR_LA && c <= CHAR_LZ) ||
                    (c >= CHAR_UA && c <= CHAR_UZ) ||
                    (c >= CHAR_1 && c <= CHAR_9);
   endfunction

endpackage

// ===== src/exptok_if.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer channels
// Valid/ready channels for input bytes and for result words.
// ----------------------------------------------------------------------------
interface exptok_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       end_req;

   modport source(output valid, output ch, output end_req, input ready);
   modport sink(input valid, input ch, input end_req, output ready);
endinterface

interface exptok_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  code;
   logic [9:0]  position;
   logic [10:0] length;
   logic        ok;
   logic        run_last;

   modport source(output valid, output kind, output code, output position,
                  output length, output ok, output run_last, input ready);
   modport sink(input valid, input kind, input code, input position,
                input length, input ok, input run_last, output ready);
endinterface

// ===== src/expression_tokenizer_unit.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer: the result words of each accepted byte are registered in the result queue.
// Throughput: one input word per cycle; a word that ends a token word gives two results,
// and input stalls while the four-word result queue holds more than two words.
// Reset (synchronous): clears the lexer state and empties the result queue.
// ----------------------------------------------------------------------------
module expression_tokenizer_unit import exptok_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   exptok_req_if.sink   req_if,
   exptok_rsp_if.source rsp_if
);

   // The lexer classifies each accepted byte against its current word
   // state combinationally. Any result words it produces, at most two,
   // are written straight into the result queue, which is the output
   // register stage. The output channel drains the queue one word a cycle while ready is high.

   logic             req_accept;
   logic             rsp_accept;
   lex_out_type      lex_out;
   result_type       head;
   logic             head_valid;
   logic [LVL_W-1:0] level;

   // Input is taken only while the queue has room for the worst case of
   // two result words, so no push can ever be lost.
   assign req_if.ready = (level <= LVL_W'(RSP_DEPTH - 2));
   assign req_accept   = req_if.valid && req_if.ready;
   assign rsp_accept   = head_valid && rsp_if.ready;

   exptok_lexer u_lexer (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .ch      (req_if.ch),
      .end_req (req_if.end_req),
      .lex_out (lex_out)
   );

   exptok_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (lex_out),
      .pop        (rsp_accept),
      .head       (head),
      .head_valid (head_valid),
      .level      (level)
   );

   // The head of the queue is presented directly on the output channel.
   assign rsp_if.valid    = head_valid;
   assign rsp_if.kind     = head.kind;
   assign rsp_if.code     = head.code;
   assign rsp_if.position = head.position;
   assign rsp_if.length   = head.length;
   assign rsp_if.ok       = head.ok;
   assign rsp_if.run_last = head.run_last;

   // The queue never holds more words than it has entries.
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level <= LVL_W'(RSP_DEPTH))
      else $error("result queue level exceeds its depth");

   // An accepted end marker always leaves at least the end result queued.
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.end_req) |=> rsp_if.valid)
      else $error("end marker produced no result word");

   // With an empty queue the block must always take input.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      (level == '0) |-> req_if.ready)
      else $error("input stalled with an empty result queue");

   // An end marker always pushes its own result as the last of the word.
   a_end_pushes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_if.end_req) |-> (lex_out.count != 2'd0))
      else $error("end marker pushed no result");

endmodule

// ===== src/exptok_lexer.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer lexer core
// Holds the word state and classifies one accepted byte per cycle.
// ----------------------------------------------------------------------------
module exptok_lexer import exptok_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  logic [7:0]  ch,
   input  logic        end_req,
   output lex_out_type lex_out
);

   logic [CNT_W-1:0]      char_count_ff, char_count_in;
   logic [9:0]            word_start_ff, word_start_in;
   logic [CNT_W-1:0]      word_length_ff, word_length_in;
   logic                  number_valid_ff, number_valid_in;
   logic                  dot_seen_ff, dot_seen_in;
   logic                  prev_was_dot_ff, prev_was_dot_in;
   logic                  variable_valid_ff, variable_valid_in;
   logic [NAME_COUNT-1:0] name_mask_ff, name_mask_in;
   logic                  error_seen_ff, error_seen_in;

   logic [7:0]  c_fold;
   logic        is_space;
   logic        op_hit;
   logic [2:0]  op_idx;
   logic        name_hit;
   logic [3:0]  name_idx;
   logic        word_open;
   logic        tail_valid;
   logic        flush_valid;
   logic        flush_err;
   result_type  flush_res;
   result_type  tail_res;

   // Character folding and operator lookup.
   always_comb begin
      c_fold   = (ch >= CHAR_UA && ch <= CHAR_UZ) ? (ch | CASE_BIT) : ch;
      is_space = (ch == CHAR_SPACE);
      op_hit   = 1'b0;
      op_idx   = '0;
      for (int i = OP_COUNT - 1; i >= 0; i--) begin
         if (OP_ROM[i] == c_fold) begin
            op_hit = 1'b1;
            op_idx = 3'(i);
         end
      end
   end

   // Classification of the pending word, lowest matching name first.
   always_comb begin
      name_hit = 1'b0;
      name_idx = '0;
      for (int i = NAME_COUNT - 1; i >= 0; i--) begin
         if (name_mask_ff[i] && word_length_ff == CNT_W'(NAME_LEN[i])) begin
            name_hit = 1'b1;
            name_idx = 4'(i);
         end
      end
      word_open       = (word_length_ff != '0);
      flush_res       = '0;
      flush_res.position = word_start_ff;
      flush_res.length   = sat_len(word_length_ff);
      flush_err       = 1'b0;
      priority if (number_valid_ff && !prev_was_dot_ff) begin
         flush_res.kind = KIND_NUMBER;
      end else if (name_hit && name_idx < 4'(FUNC_COUNT)) begin
         flush_res.kind = KIND_FUNCTION;
         flush_res.code = name_idx;
      end else if (name_hit) begin
         flush_res.kind = KIND_CONSTANT;
         flush_res.code = name_idx - 4'(FUNC_COUNT);
      end else if (variable_valid_ff) begin
         flush_res.kind = KIND_VARIABLE;
      end else begin
         flush_res.kind = KIND_INVALID;
         flush_err      = word_open;
      end
   end

   // Result words of this byte.
   always_comb begin
      tail_valid  = end_req || (!is_space && op_hit);
      flush_valid = tail_valid && word_open;
      tail_res    = '0;
      tail_res.position = sat_pos(char_count_ff);
      tail_res.run_last = 1'b1;
      if (end_req) begin
         tail_res.kind = KIND_END;
         tail_res.ok   = !(error_seen_ff || flush_err);
      end else begin
         tail_res.kind   = KIND_OPERATOR;
         tail_res.code   = {1'b0, op_idx};
         tail_res.length = 11'd1;
      end
      lex_out = '0;
      if (accept && flush_valid) begin
         lex_out.count  = 2'd2;
         lex_out.first  = flush_res;
         lex_out.second = tail_res;
      end else if (accept && tail_valid) begin
         lex_out.count = 2'd1;
         lex_out.first = tail_res;
      end
   end

   // Next state.
   always_comb begin
      char_count_in     = char_count_ff;
      word_start_in     = word_start_ff;
      word_length_in    = word_length_ff;
      number_valid_in   = number_valid_ff;
      dot_seen_in       = dot_seen_ff;
      prev_was_dot_in   = prev_was_dot_ff;
      variable_valid_in = variable_valid_ff;
      name_mask_in      = name_mask_ff;
      error_seen_in     = error_seen_ff;
      if (accept && end_req) begin
         char_count_in     = '0;
         word_start_in     = '0;
         word_length_in    = '0;
         number_valid_in   = 1'b1;
         dot_seen_in       = 1'b0;
         prev_was_dot_in   = 1'b0;
         variable_valid_in = 1'b1;
         name_mask_in      = '1;
         error_seen_in     = 1'b0;
      end else if (accept && !is_space) begin
         if (char_count_ff >= CNT_W'(MAX_EXPR_LEN)) error_seen_in = 1'b1;
         else char_count_in = char_count_ff + CNT_W'(1);
         if (op_hit) begin
            if (flush_err) error_seen_in = 1'b1;
            word_length_in    = '0;
            number_valid_in   = 1'b1;
            dot_seen_in       = 1'b0;
            prev_was_dot_in   = 1'b0;
            variable_valid_in = 1'b1;
            name_mask_in      = '1;
         end else begin
            if (!word_open) word_start_in = sat_pos(char_count_ff);
            if (c_fold >= CHAR_0 && c_fold <= CHAR_9) begin
               prev_was_dot_in = 1'b0;
            end else if (c_fold == CHAR_DOT) begin
               if (!word_open || dot_seen_ff) number_valid_in = 1'b0;
               dot_seen_in     = 1'b1;
               prev_was_dot_in = 1'b1;
            end else begin
               number_valid_in = 1'b0;
               prev_was_dot_in = 1'b0;
            end
            if (!is_var_char(c_fold)) variable_valid_in = 1'b0;
            for (int i = 0; i < NAME_COUNT; i++) begin
               if (word_length_ff >= CNT_W'(NAME_LEN[i]) ||
                   NAME_ROM[i][8*word_length_ff[1:0] +: 8] != c_fold) begin
                  name_mask_in[i] = 1'b0;
               end
            end
            if (word_length_ff < CNT_W'(MAX_EXPR_LEN)) begin
               word_length_in = word_length_ff + CNT_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff     <= '0;
         word_start_ff     <= '0;
         word_length_ff    <= '0;
         number_valid_ff   <= 1'b1;
         dot_seen_ff       <= 1'b0;
         prev_was_dot_ff   <= 1'b0;
         variable_valid_ff <= 1'b1;
         name_mask_ff      <= '1;
         error_seen_ff     <= 1'b0;
      end else begin
         char_count_ff     <= char_count_in;
         word_start_ff     <= word_start_in;
         word_length_ff    <= word_length_in;
         number_valid_ff   <= number_valid_in;
         dot_seen_ff       <= dot_seen_in;
         prev_was_dot_ff   <= prev_was_dot_in;
         variable_valid_ff <= variable_valid_in;
         name_mask_ff      <= name_mask_in;
         error_seen_ff     <= error_seen_in;
      end
   end

endmodule

// ===== src/exptok_rsp_fifo.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer result queue
// Small queue that takes up to two result words per cycle and gives at most one.
// ----------------------------------------------------------------------------
module exptok_rsp_fifo import exptok_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  lex_out_type      push,
   input  logic             pop,
   output result_type       head,
   output logic             head_valid,
   output logic [LVL_W-1:0] level
);

   result_type       entry_ff [RSP_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [PTR_W-1:0] wr_next;

   always_comb begin
      wr_next    = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in  = wr_ptr_ff + PTR_W'(push.count);
      rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
      level_in   = level_ff + LVL_W'(push.count) - LVL_W'(pop);
      head       = entry_ff[rd_ptr_ff];
      head_valid = (level_ff != '0);
      level      = level_ff;
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.count == 2'd2) entry_ff[wr_next] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

// ===== dv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Expression tokenizer testbench
// Streams expression bytes into the tokenizer and checks every result word
// against a cycle-free prediction of the lexer, under random idling on both
// channels, a long output stall and expressions past the length limit.
// ----------------------------------------------------------------------------
module tb_top;
   import exptok_pkg::*;

   localparam int unsigned RUN_LIMIT_CYCLES = 500_000;
   localparam int unsigned DRAIN_LIMIT      = 20_000;
   // The result queue is four deep behind a combinational lexer, so the settle wait
   // after the last expected word is enough to catch any stray extra word.
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned MAX_REPORTS      = 10;

   logic clock;
   logic reset;

   exptok_req_if req_ch();
   exptok_rsp_if rsp_ch();

   expression_tokenizer_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   // Idle percentages for each side, and the length of a forced output stall.
   int unsigned req_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned hold_cycles  = 0;

   int unsigned words_sent         = 0;
   int unsigned results_checked    = 0;
   int unsigned expressions_closed = 0;
   int unsigned fault_count        = 0;

   // Tokens that the lexer owes us, oldest first.
   result_type expected_tokens[$];
   // Tokens caused by the word being predicted right now.
   result_type step_results[$];
   // Text of the expression being built by the random generator.
   logic [7:0] expr_text[$];

   // Lexer state as the prediction sees it.
   int unsigned kept_count;
   int unsigned tok_start;
   int unsigned tok_len;
   logic        num_ok;
   logic        dot_found;
   logic        last_dot;
   logic        var_ok;
   logic [15:0] name_hits;
   logic        bad_seen;

   // -------------------------------------------------------------------------
   // Prediction
   // -------------------------------------------------------------------------

   // Forget the word in progress; called after a word has been classified.
   function automatic void clear_token();
      tok_len   = 0;
      num_ok    = 1'b1;
      dot_found = 1'b0;
      last_dot  = 1'b0;
      var_ok    = 1'b1;
      name_hits = '1;
   endfunction

   // Back to the state after reset, which is also the state after an end word.
   function automatic void restart_lexer();
      kept_count = 0;
      tok_start  = 0;
      bad_seen   = 1'b0;
      clear_token();
   endfunction

   // Builds one result word with the position and length saturated the way
   // the output fields are.
   function automatic result_type make_result(kind_type k, int unsigned cd,
                                              int unsigned pos, int unsigned len,
                                              logic ok_bit);
      result_type r;
      r.kind     = k;
      r.code     = 4'(cd);
      r.position = (pos > POS_SAT) ? 10'(POS_SAT) : 10'(pos);
      r.length   = (len > LEN_SAT) ? 11'(LEN_SAT) : 11'(len);
      r.ok       = ok_bit;
      r.run_last = 1'b0;
      return r;
   endfunction

   // Classifies the pending word, if there is one. The order matters: a valid
   // number wins over everything, then the first full name match, then the
   // variable character set. Whatever is left is an invalid word and spoils
   // the expression.
   function automatic void close_token();
      kind_type    k;
      int unsigned cd;
      int          hit;
      if (tok_len == 0) return;
      k   = KIND_INVALID;
      cd  = 0;
      hit = -1;
      if (num_ok && !last_dot) begin
         k = KIND_NUMBER;
      end else begin
         for (int i = 0; i < NAME_COUNT; i++)
            if (hit < 0 && name_hits[i] && NAME_LEN[i] == tok_len) hit = i;
         if (hit >= FUNC_COUNT) begin
            k  = KIND_CONSTANT;
            cd = hit - FUNC_COUNT;
         end else if (hit >= 0) begin
            k  = KIND_FUNCTION;
            cd = hit;
         end else if (var_ok) begin
            k = KIND_VARIABLE;
         end else begin
            bad_seen = 1'b1;
         end
      end
      step_results.insert(step_results.size(),
                          make_result(k, cd, tok_start, tok_len, 1'b0));
      clear_token();
   endfunction

   // Adds one folded, non-operator character to the pending word.
   function automatic void grow_token(logic [7:0] c, int unsigned pos);
      logic [7:0] folded;
      if (tok_len == 0) tok_start = pos;
      if (c >= CHAR_0 && c <= CHAR_9) begin
         last_dot = 1'b0;
      end else if (c == CHAR_DOT) begin
         // A dot at the very start or a second dot ruins the number form.
         if (tok_len == 0 || dot_found) num_ok = 1'b0;
         dot_found = 1'b1;
         last_dot  = 1'b1;
      end else begin
         num_ok   = 1'b0;
         last_dot = 1'b0;
      end
      // Variables take underscore, letters of either case and digits 1 to 9;
      // the zero digit is deliberately left out.
      folded = c | CASE_BIT;
      if (!(c == CHAR_UNDER || (folded >= CHAR_LA && folded <= CHAR_LZ) ||
            (c >= CHAR_1 && c <= CHAR_9)))
         var_ok = 1'b0;
      for (int i = 0; i < NAME_COUNT; i++) begin
         if (tok_len >= NAME_LEN[i]) name_hits[i] = 1'b0;
         else if (NAME_ROM[i][8*tok_len +: 8] != c) name_hits[i] = 1'b0;
      end
      if (tok_len < MAX_EXPR_LEN) tok_len++;
   endfunction

   // Works out the result words that one accepted input word causes and
   // queues them, with run_last on the final one.
   function automatic void predict_word(logic [7:0] c_in, logic end_bit);
      logic [7:0]  c;
      int unsigned pos;
      int          op;
      step_results.delete();
      c = c_in;
      if (end_bit) begin
         close_token();
         step_results.insert(step_results.size(),
                             make_result(KIND_END, 0, kept_count, 0, !bad_seen));
         restart_lexer();
      end else if (c != CHAR_SPACE) begin
         if (c >= CHAR_UA && c <= CHAR_UZ) c = c | CASE_BIT;
         pos = kept_count;
         // Past the limit the character still counts as text, but the
         // expression can no longer be reported clean.
         if (kept_count >= MAX_EXPR_LEN) bad_seen = 1'b1;
         else kept_count++;
         op = -1;
         for (int i = 0; i < OP_COUNT; i++)
            if (op < 0 && OP_ROM[i] == c) op = i;
         if (op >= 0) begin
            close_token();
            step_results.insert(step_results.size(),
                                make_result(KIND_OPERATOR, op, pos, 1, 1'b0));
         end else begin
            grow_token(c, pos);
         end
      end
      if (step_results.size() > 0) step_results[step_results.size()-1].run_last = 1'b1;
      foreach (step_results[i]) expected_tokens.insert(expected_tokens.size(), step_results[i]);
   endfunction

   // -------------------------------------------------------------------------
   // Clock, reset and the watchdog
   // -------------------------------------------------------------------------

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A hung handshake or a missing result word ends up here.
   initial begin
      #(RUN_LIMIT_CYCLES * 10);
      $display("[FAIL] regression broken");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Input side
   // -------------------------------------------------------------------------

   // Offers one word and waits for the lexer to take it. Valid is left high
   // afterwards so back-to-back words need no extra edge; any idle gap or
   // pause lowers it first, in a later time step.
   task automatic send_word(input logic [7:0] c, input logic end_bit);
      while ($urandom_range(99) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.ch      <= c;
      req_ch.end_req <= end_bit;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      // The word was taken at this edge, so its tokens are owed from now on.
      predict_word(c, end_bit);
      words_sent++;
   endtask

   // Closes the expression; the byte that rides along is meant to be ignored.
   task automatic send_end();
      send_word(8'($urandom_range(255)), 1'b1);
      expressions_closed++;
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++) send_word(8'(s[i]), 1'b0);
   endtask

   // Drops valid and waits until every owed token has come back, bounded.
   task automatic wait_for_results(input int unsigned limit);
      int unsigned waited;
      waited = 0;
      req_ch.valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_tokens.size() != 0 && waited < limit);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Random expression text
   // -------------------------------------------------------------------------

   function automatic void add_byte(logic [7:0] c);
      expr_text.insert(expr_text.size(), c);
   endfunction

   // Appends a character, turning lower-case letters to capitals now and then
   // so that case folding is exercised everywhere.
   function automatic void push_char(logic [7:0] c);
      if (c >= CHAR_LA && c <= CHAR_LZ && $urandom_range(3) == 0) c = c & ~CASE_BIT;
      add_byte(c);
   endfunction

   function automatic void push_name(int unsigned k, int unsigned n);
      for (int j = 0; j < n; j++) push_char(NAME_ROM[k][8*j +: 8]);
   endfunction

   // One character from the variable set: underscore, digits 1-9 or a letter.
   function automatic logic [7:0] name_char();
      int unsigned r;
      r = $urandom_range(35);
      if (r == 0) return CHAR_UNDER;
      if (r < 10) return 8'(CHAR_0 + r);
      return 8'(CHAR_LA + r - 10);
   endfunction

   function automatic void push_operator();
      add_byte(OP_ROM[$urandom_range(OP_COUNT-1)]);
   endfunction

   function automatic bit is_op_byte(logic [7:0] c);
      for (int i = 0; i < OP_COUNT; i++)
         if (OP_ROM[i] == c) return 1'b1;
      return 1'b0;
   endfunction

   // Appends one word, mostly of a valid kind, with a share of near misses.
   function automatic void add_word();
      int unsigned n;
      int unsigned k;
      logic [7:0]  c;
      case ($urandom_range(9))
         0, 1: begin
            // Digits with a dot somewhere or none: a dot inside gives a number, at
            // either end or doubled it does not.
            n = $urandom_range(1, 6);
            k = $urandom_range(n + 2);
            for (int i = 0; i < n; i++) begin
               if (i == k) add_byte(CHAR_DOT);
               add_byte(8'(CHAR_0 + $urandom_range(9)));
            end
            if (k == n) add_byte(CHAR_DOT);
            if ($urandom_range(11) == 0) begin
               add_byte(CHAR_DOT);
               add_byte(8'(CHAR_0 + $urandom_range(9)));
            end
         end
         2, 3: begin
            k = $urandom_range(FUNC_COUNT - 1);
            push_name(k, NAME_LEN[k]);
         end
         4: begin
            k = FUNC_COUNT + $urandom_range(NAME_COUNT - FUNC_COUNT - 1);
            push_name(k, NAME_LEN[k]);
         end
         5, 6: begin
            n = $urandom_range(1, 6);
            repeat (n) push_char(name_char());
         end
         7: begin
            // A name cut short or with something tacked on.
            k = $urandom_range(NAME_COUNT - 1);
            if ($urandom_range(1) == 0) begin
               push_name(k, NAME_LEN[k] - 1);
            end else begin
               push_name(k, NAME_LEN[k]);
               push_char(name_char());
            end
         end
         8: begin
            // Arbitrary bytes; operators and the space get the top bit set so
            // the word stays one word.
            n = $urandom_range(1, 4);
            repeat (n) begin
               c = 8'($urandom_range(255));
               if (c == CHAR_SPACE || is_op_byte(c)) c = c | 8'h80;
               add_byte(c);
            end
         end
         default: begin
            // Looks like a variable but holds a zero digit or a dot.
            push_char(8'(CHAR_LA + $urandom_range(25)));
            add_byte($urandom_range(1) ? CHAR_0 : CHAR_DOT);
            if ($urandom_range(1) == 0) push_char(name_char());
         end
      endcase
   endfunction

   // Sends one piece of text, closed by an end word when asked. A well-formed
   // piece alternates words and operators with stray spaces; noise is raw
   // bytes of any value.
   task automatic send_expression(input bit well_formed, input bit close_it);
      int unsigned n;
      expr_text.delete();
      if (well_formed) begin
         n = $urandom_range(1, 10);
         if ($urandom_range(4) == 0) push_operator();
         for (int i = 0; i < n; i++) begin
            add_word();
            if (i < n - 1 || $urandom_range(3) == 0) push_operator();
            if ($urandom_range(7) == 0) push_operator();
         end
      end else begin
         n = $urandom_range(1, 16);
         repeat (n) add_byte(8'($urandom_range(255)));
      end
      foreach (expr_text[i]) begin
         if ($urandom_range(19) == 0) send_word(CHAR_SPACE, 1'b0);
         send_word(expr_text[i], 1'b0);
      end
      if (close_it) send_end();
   endtask

   // -------------------------------------------------------------------------
   // Tests
   // -------------------------------------------------------------------------

   // End words with nothing pending give a clean end result and nothing else;
   // a lone space must not change that.
   task automatic test_empty_expressions();
      send_end();
      send_word(CHAR_SPACE, 1'b0);
      send_end();
   endtask

   // All eight operators, a function name and a constant in mixed case,
   // a decimal number and plain variables.
   task automatic test_operators_and_names();
      send_string("(a+1.5)-C_E*Sqrt/2^x,y");
      send_end();
   endtask

   // Dots at the end, at the start and doubled, a leading zero, and control
   // and high bytes inside a word, which make it invalid.
   task automatic test_number_forms();
      send_string("1.+.5*1.2.3/09,");
      send_word(8'h00, 1'b0);
      send_word(8'hFF, 1'b0);
      send_word(8'h7F, 1'b0);
      send_end();
   endtask

   // Random words, operators and noise, appended to one open expression that
   // the length test goes on with and closes.
   task automatic test_random_phase(input int unsigned sender_pct,
                                    input int unsigned receiver_pct,
                                    input int unsigned count);
      int unsigned stop_at;
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      stop_at      = words_sent + count;
      while (words_sent < stop_at) send_expression($urandom_range(4) != 0, 1'b0);
   endtask

   // Goes on with the open expression, without idling, until it fills the
   // limit, then runs past it so the count and the positions saturate and
   // the end word must report the expression unclean.
   task automatic test_length_limit();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      while (kept_count < MAX_EXPR_LEN) send_expression($urandom_range(4) != 0, 1'b0);
      send_string("+1");
      send_end();
   endtask

   // The output side stops taking words for a long stretch while the input
   // keeps offering, so the result queue fills and the block stalls its
   // input. Afterwards the input pauses until every token is back.
   task automatic test_output_stall();
      int unsigned stop_at;
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_cycles  = 300;
      stop_at      = words_sent + 24;
      while (words_sent < stop_at) send_expression(1'b1, 1'b1);
      wait_for_results(DRAIN_LIMIT);
   endtask

   // -------------------------------------------------------------------------
   // Output side: drives ready and checks each accepted result word
   // -------------------------------------------------------------------------

   function automatic void report_fault(string what, result_type want, result_type got);
      fault_count++;
      if (fault_count <= MAX_REPORTS) begin
         $display("%0t %s: expected kind=%0d code=%0d pos=%0d len=%0d ok=%0b last=%0b",
                  $time, what, want.kind, want.code, want.position, want.length,
                  want.ok, want.run_last);
         $display("%0t %s: actual   kind=%0d code=%0d pos=%0d len=%0d ok=%0b last=%0b",
                  $time, what, got.kind, got.code, got.position, got.length,
                  got.ok, got.run_last);
      end
   endfunction

   initial begin : result_checker
      result_type got;
      result_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got.kind     = kind_type'(rsp_ch.kind);
            got.code     = rsp_ch.code;
            got.position = rsp_ch.position;
            got.length   = rsp_ch.length;
            got.ok       = rsp_ch.ok;
            got.run_last = rsp_ch.run_last;
            results_checked++;
            if (expected_tokens.size() == 0) begin
               want = '0;
               report_fault("result word with nothing expected", want, got);
            end else begin
               want = expected_tokens.pop_front();
               if (got.kind !== want.kind || got.code !== want.code ||
                   got.position !== want.position || got.length !== want.length ||
                   got.ok !== want.ok || got.run_last !== want.run_last)
                  report_fault("result word mismatch", want, got);
            end
         end
         // A forced stall is counted down here; otherwise ready follows the
         // idle percentage of the current phase.
         if (hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Test sequence
   // -------------------------------------------------------------------------

   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.ch      <= '0;
      req_ch.end_req <= 1'b0;
      restart_lexer();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words run with light idling on both sides.
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      test_empty_expressions();
      test_operators_and_names();
      test_number_forms();

      // Random text in one long expression: a slow receiver first, then a slow
      // sender, then neither while it runs past the length limit.
      test_random_phase(15, 85, 300);
      test_random_phase(85, 15, 300);
      test_length_limit();
      test_output_stall();

      rsp_idle_pct = 0;
      wait_for_results(DRAIN_LIMIT);
      if (expected_tokens.size() != 0) begin
         fault_count += expected_tokens.size();
         $display("%0d expected result words never arrived", expected_tokens.size());
      end

      $display("Lexed %0d input words in %0d expressions and checked %0d result words,",
               words_sent, expressions_closed, results_checked);
      $display("covering all token kinds, bad numbers, raw bytes, overflow and a stall.");
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
